// File: hw/rtl/tgp_pkg.sv
// tgp_pkg: shared widths, the division cell transaction type and the gamma table builder
// no dependencies
package tgp_pkg;

   localparam int IN_W          = 24;
   localparam int OUT_W         = 16;
   localparam int AB_W          = 34;
   localparam int NUM_W         = 58;
   localparam int QUO_W         = 16;
   localparam int DEF_FRAC_BITS = 16;
   localparam int DEF_TBL_BITS  = 10;
   localparam int DEF_GAMMA     = 4545;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [NUM_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             sat;
   } div_state_type;

   function automatic longint unsigned isqrt64(input longint unsigned a_arg);
      longint unsigned a;
      longint unsigned res;
      longint unsigned bitv;
      a    = a_arg;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > a) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (a >= res + bitv) begin
            a   = a - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned log2_q32(input longint unsigned n);
      longint unsigned k;
      longint unsigned m;
      longint unsigned frac;
      k    = 0;
      frac = 0;
      while (k < 31 && (n >> (k + 1)) != 0) k = k + 1;
      m = n << (31 - k);
      for (int j = 31; j >= 0; j--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            frac = frac | (64'd1 << j);
            m    = m >> 1;
         end
      end
      return (k << 32) | frac;
   endfunction

   function automatic logic [OUT_W-1:0] gamma_entry(input int idx, input int tbits,
                                                    input int gam);
      longint unsigned roots [33];
      longint unsigned tmax;
      longint unsigned d;
      longint unsigned p;
      longint unsigned q;
      longint unsigned f;
      longint unsigned u;
      longint unsigned a;
      longint unsigned s;
      longint unsigned e;
      tmax = (64'd1 << tbits) - 1;
      if (idx == 0) return '0;
      roots[0] = 64'd1 << 32;
      for (int j = 1; j <= 32; j++) roots[j] = isqrt64(roots[j-1] << 31);
      d = log2_q32(tmax) - log2_q32(longint'(idx));
      p = (d * longint'(gam) + 64'd5000) / 64'd10000;
      q = p >> 32;
      f = p & 64'hFFFF_FFFF;
      a = 64'd1 << 31;
      if (f == 0) begin
         s = q;
      end else begin
         u = (64'd1 << 32) - f;
         for (int j = 1; j <= 32; j++)
            if (((u >> (32 - j)) & 64'd1) != 0) a = (a * roots[j]) >> 31;
         s = q + 1;
      end
      if (s >= 32) begin
         e = 0;
      end else begin
         e = (64'd65535 * a + (64'd1 << (30 + s))) >> (31 + s);
         if (e > 64'd65535) e = 64'd65535;
      end
      return e[OUT_W-1:0];
   endfunction

endpackage

// File: hw/rtl/tgp_front.sv
// tgp_front: two multiply stages forming numerator and denominator of the filmic curve
// depends on tgp_pkg
module tgp_front #(
   parameter int FRAC_BITS = tgp_pkg::DEF_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        en_a,
   input  logic                        en_b,
   input  logic [tgp_pkg::IN_W-1:0]    hdr,
   output tgp_pkg::div_state_type      state_out
);
   import tgp_pkg::*;

   localparam logic [NUM_W-1:0] SCALE   = NUM_W'(1) << FRAC_BITS;
   localparam logic [NUM_W-1:0] DEN_OFS = NUM_W'(14) * SCALE * SCALE;

   logic [IN_W-1:0]  v_ff;
   logic [AB_W-1:0]  a_ff, a_in;
   logic [AB_W-1:0]  b_ff, b_in;
   div_state_type    st_ff, st_in;

   always_comb begin
      a_in = AB_W'(251) * AB_W'(hdr) + (AB_W'(3) << FRAC_BITS);
      b_in = AB_W'(243) * AB_W'(hdr) + (AB_W'(59) << FRAC_BITS);
      st_in.rem = NUM_W'(v_ff) * NUM_W'(a_ff);
      st_in.den = NUM_W'(v_ff) * NUM_W'(b_ff) + DEN_OFS;
      st_in.quo = '0;
      st_in.sat = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         v_ff <= hdr;
         a_ff <= a_in;
         b_ff <= b_in;
      end
      if (en_b) st_ff <= st_in;
   end

   assign state_out = st_ff;

endmodule

// File: hw/rtl/tgp_div_cell.sv
// tgp_div_cell: one restoring division step producing one quotient bit
// depends on tgp_pkg
module tgp_div_cell #(
   parameter bit IS_FIRST = 1'b0
) (
   input  logic                   clock,
   input  logic                   en,
   input  tgp_pkg::div_state_type state_in,
   output tgp_pkg::div_state_type state_out
);
   import tgp_pkg::*;

   logic [NUM_W:0]  rem2;
   div_state_type   st_ff, st_in;

   always_comb begin
      rem2      = {state_in.rem, 1'b0};
      st_in.den = state_in.den;
      if (rem2 >= {1'b0, state_in.den}) begin
         st_in.rem = NUM_W'(rem2 - {1'b0, state_in.den});
         st_in.quo = {state_in.quo[QUO_W-2:0], 1'b1};
      end else begin
         st_in.rem = rem2[NUM_W-1:0];
         st_in.quo = {state_in.quo[QUO_W-2:0], 1'b0};
      end
      // ratio of one or more saturates
      st_in.sat = IS_FIRST ? (state_in.rem >= state_in.den) : state_in.sat;
   end

   always_ff @(posedge clock) begin
      if (en) st_ff <= st_in;
   end

   assign state_out = st_ff;

endmodule

// File: hw/rtl/tgp_gamma_rom.sv
// tgp_gamma_rom: gamma lookup table with registered read, built at elaboration
// depends on tgp_pkg
module tgp_gamma_rom #(
   parameter int GAMMA_TABLE_BITS      = tgp_pkg::DEF_TBL_BITS,
   parameter int GAMMA_TEN_THOUSANDTHS = tgp_pkg::DEF_GAMMA
) (
   input  logic                          clock,
   input  logic                          en,
   input  tgp_pkg::div_state_type        state_in,
   output logic [tgp_pkg::OUT_W-1:0]     ldr
);
   import tgp_pkg::*;

   localparam int TBL_SIZE = 1 << GAMMA_TABLE_BITS;
   typedef logic [OUT_W-1:0] tbl_type [TBL_SIZE];

   function automatic tbl_type build_table();
      tbl_type t;
      for (int i = 0; i < TBL_SIZE; i++)
         t[i] = gamma_entry(i, GAMMA_TABLE_BITS, GAMMA_TEN_THOUSANDTHS);
      return t;
   endfunction

   localparam tbl_type TBL = build_table();

   logic [QUO_W-1:0]            t_val;
   logic [GAMMA_TABLE_BITS-1:0] idx;
   logic [OUT_W-1:0]            ldr_ff;

   always_comb begin
      t_val = state_in.sat ? '1 : state_in.quo;
      idx   = t_val[QUO_W-1 -: GAMMA_TABLE_BITS];
   end

   always_ff @(posedge clock) begin
      if (en) ldr_ff <= TBL[idx];
   end

   assign ldr = ldr_ff;

endmodule

// File: hw/rtl/aces_tonemap_gamma_pixel_unit.sv
// aces_tonemap_gamma_pixel_unit: filmic tone map, gamma correction, one rgb pixel per cycle unless stalled
// depends on tgp_pkg, tgp_front, tgp_div_cell, tgp_gamma_rom
//
//   channel   ports                               transaction
//   request   req_valid req_ready req_hdr_*       one hdr pixel, three q8.16 channels
//   response  rsp_valid rsp_ready rsp_ldr_*       one ldr pixel, three q0.16 channels
//
// pipeline: two multiply stages, sixteen division cells, one table read
// one pixel accepted every cycle unless the response side stalls; the division cell chain sets the depth
// each stage holds while the stage after it is full and stalled
// reset clears the stage valid bits only; the gamma table is constant
module aces_tonemap_gamma_pixel_unit #(
   parameter int FRAC_BITS             = tgp_pkg::DEF_FRAC_BITS,
   parameter int GAMMA_TABLE_BITS      = tgp_pkg::DEF_TBL_BITS,
   parameter int GAMMA_TEN_THOUSANDTHS = tgp_pkg::DEF_GAMMA
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [tgp_pkg::IN_W-1:0]   req_hdr_red,
   input  logic [tgp_pkg::IN_W-1:0]   req_hdr_green,
   input  logic [tgp_pkg::IN_W-1:0]   req_hdr_blue,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [tgp_pkg::OUT_W-1:0]  rsp_ldr_red,
   output logic [tgp_pkg::OUT_W-1:0]  rsp_ldr_green,
   output logic [tgp_pkg::OUT_W-1:0]  rsp_ldr_blue
);
   import tgp_pkg::*;

   localparam int NSTG = QUO_W + 3;

   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] go;
   logic [IN_W-1:0]  hdr  [3];
   logic [OUT_W-1:0] ldr  [3];

   assign hdr[0] = req_hdr_red;
   assign hdr[1] = req_hdr_green;
   assign hdr[2] = req_hdr_blue;

   always_comb begin
      go[NSTG-1] = !vld_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) go[k] = !vld_ff[k] || go[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (go[0]) vld_ff[0] <= req_valid;
         for (int k = 1; k < NSTG; k++)
            if (go[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_chan
      div_state_type chain [QUO_W+1];

      tgp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
         .clock(clock), .en_a(go[0]), .en_b(go[1]),
         .hdr(hdr[c]), .state_out(chain[0])
      );

      for (genvar k = 0; k < QUO_W; k++) begin : g_cell
         tgp_div_cell #(.IS_FIRST(k == 0)) u_cell (
            .clock(clock), .en(go[k+2]),
            .state_in(chain[k]), .state_out(chain[k+1])
         );
      end

      tgp_gamma_rom #(
         .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS),
         .GAMMA_TEN_THOUSANDTHS(GAMMA_TEN_THOUSANDTHS)
      ) u_rom (
         .clock(clock), .en(go[NSTG-1]),
         .state_in(chain[QUO_W]), .ldr(ldr[c])
      );
   end

   assign req_ready     = go[0];
   assign rsp_valid     = vld_ff[NSTG-1];
   assign rsp_ldr_red   = ldr[0];
   assign rsp_ldr_green = ldr[1];
   assign rsp_ldr_blue  = ldr[2];

endmodule
